// File: rtl/rshe_pkg.sv
// ----------------------------------------------------------------------------
// rshe_pkg
// Constants, status codes and fixed-point helpers of the spherical harmonic
// evaluator.
// ----------------------------------------------------------------------------
package rshe_pkg;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ORDER  = 2'd1;
  localparam logic [1:0] ST_ORIGIN = 2'd2;

  localparam logic [32:0] HALF_PI_Q28      = 33'd421657428;
  localparam logic [39:0] HALF_PI_Q28_HALF = 40'd210828714;
  localparam logic [31:0] Q60_HI           = 32'h1921FB54;
  localparam logic [31:0] Q60_LO           = 32'h442D1847;
  localparam logic signed [33:0] INV_SQRT_4PI_Q28 = 34'sd75724244;
  localparam logic signed [33:0] SQRT2_Q30        = 34'sd1518500250;
  localparam logic signed [33:0] ONE30            = 34'sd1073741824;

  // round to nearest, ties toward +inf
  function automatic logic signed [67:0] rnd30(input logic signed [67:0] v);
    return (v + 68'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [67:0] rnd28(input logic signed [67:0] v);
    return (v + 68'sd134217728) >>> 28;
  endfunction

  function automatic logic signed [33:0] clamp31(input logic signed [67:0] v);
    if (v > 68'sd2147483648) return 34'sd2147483648;
    if (v < -68'sd2147483648) return -34'sd2147483648;
    return 34'(v);
  endfunction

  function automatic logic signed [33:0] clamp30(input logic signed [67:0] v);
    if (v > 68'sd1073741824) return ONE30;
    if (v < -68'sd1073741824) return -ONE30;
    return 34'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  // rounded quotient, capped at one, with sign applied
  function automatic logic signed [33:0] div_fin(input logic [63:0] q, input logic neg);
    logic [30:0] m;
    m = (q > 64'd1073741824) ? 31'd1073741824 : q[30:0];
    return neg ? -$signed({3'b000, m}) : $signed({3'b000, m});
  endfunction

  // Taylor term divisors, sine (2i)(2i+1) and cosine (2i-1)(2i)
  function automatic logic [7:0] sin_div(input logic [2:0] i);
    case (i)
      3'd1: return 8'd6;
      3'd2: return 8'd20;
      3'd3: return 8'd42;
      3'd4: return 8'd72;
      3'd5: return 8'd110;
      3'd6: return 8'd156;
      3'd7: return 8'd210;
      default: return 8'd1;
    endcase
  endfunction

  function automatic logic [7:0] cos_div(input logic [2:0] i);
    case (i)
      3'd1: return 8'd2;
      3'd2: return 8'd12;
      3'd3: return 8'd30;
      3'd4: return 8'd56;
      3'd5: return 8'd90;
      3'd6: return 8'd132;
      3'd7: return 8'd182;
      default: return 8'd1;
    endcase
  endfunction

endpackage

// File: rtl/real_spherical_harmonic_eval.sv
// Run time depends on the input form (a Cartesian point, whose normalize shifts vary,
// or an angle pair), on |m| and on l-|m|.
// Throughput: one request at a time; the next is taken once the result leaves.
// The shared restoring divider (one quotient bit a cycle) and square root unit
// (one result bit a cycle) set the run time. Reset (rst, synchronous) idles.
// ----------------------------------------------------------------------------
// real_spherical_harmonic_eval
// Real spherical harmonic Y_lm with Condon-Shortley phase, fixed point, from a
// point or from polar/azimuth angles, on one multiplier, divider and sqrt unit.
// ----------------------------------------------------------------------------
module real_spherical_harmonic_eval #(
  parameter int L_MAX = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [3:0]         degree,
  input  logic signed [4:0]  order,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  logic signed [31:0] z_coord,
  input  logic signed [31:0] polar_angle,
  input  logic signed [31:0] azimuth_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic [1:0]         status
);
  import rshe_pkg::*;

  localparam int LSAT = (L_MAX > 15) ? 15 : L_MAX;

  localparam logic [6:0] IDLE = 7'd0, START = 7'd1, DIVS = 7'd2, SQRT = 7'd3,
    NORM = 7'd4, C_SH = 7'd5, C_MX = 7'd6, C_MY = 7'd7, C_MZ = 7'd8, C_R = 7'd9,
    C_RHO = 7'd10, C_DC = 7'd11, C_DS = 7'd12, C_PH = 7'd13, C_PSH = 7'd14,
    C_PMX = 7'd15, C_PMY = 7'd16, C_PR = 7'd17, C_PDC = 7'd18, C_PDS = 7'd19,
    C_PEND = 7'd20, C_ROT = 7'd21, C_R2 = 7'd22, C_R3 = 7'd23, C_R4 = 7'd24,
    C_R5 = 7'd25, A_PH = 7'd26, A_PH2 = 7'd27, A_END = 7'd28, SC_K = 7'd29,
    SC_K2 = 7'd30, SC_K3 = 7'd31, SC_K4 = 7'd32, SC_K5 = 7'd33, SC_X = 7'd34,
    SC_X2 = 7'd35, SC_T = 7'd36, SC_T2 = 7'd37, SC_T3 = 7'd38, SC_T4 = 7'd39,
    SC_T5 = 7'd40, SC_Q = 7'd41, L_START = 7'd42, L_K = 7'd43, L_K1 = 7'd44,
    L_K2 = 7'd45, L_K3 = 7'd46, L_K4 = 7'd47, L_K5 = 7'd48, L_CHK = 7'd49,
    L_M1 = 7'd50, L_M2 = 7'd51, L_M3 = 7'd52, L_M4 = 7'd53, L_M5 = 7'd54,
    L_E = 7'd55, L_E1 = 7'd56, L_E2 = 7'd57, L_E3 = 7'd58, L_E4 = 7'd59,
    L_E5 = 7'd60, L_E6 = 7'd61, L_E7 = 7'd62, L_E8 = 7'd63, FIN = 7'd64,
    FIN2 = 7'd65, FIN3 = 7'd66, FIN4 = 7'd67, DONE = 7'd68;

  logic [6:0] state, ret, ret_sc;

  // request
  logic               func_r;
  logic [3:0]         l_r;
  logic signed [4:0]  ord_r;
  logic [4:0]         am;
  logic [31:0]        ax, ay, az;
  logic               xneg, yneg, zneg;
  logic signed [31:0] th_r, ph_r;
  logic [1:0]         status_r;
  logic signed [31:0] value_r;

  // direction
  logic [31:0]        nrm, xs, ys, zs;
  logic [4:0]         sh;
  logic [32:0]        rr;
  logic signed [33:0] c, s, cm, sm, c1, s1;
  logic signed [67:0] acc, acc2;

  // shared divider and square root
  logic [71:0]        dv_n;
  logic [32:0]        dv_d, rem;
  logic [63:0]        quo;
  logic [6:0]         cnt;
  logic [63:0]        sq_v, sq_res, sq_bit;

  // sine/cosine
  logic signed [37:0] ang;
  logic signed [8:0]  k;
  logic signed [33:0] rv, x2, ts, tc, st, ct, sc_c, sc_s;
  logic               tneg;
  logic [2:0]         ti;

  // Legendre
  logic signed [33:0] p, p0, p1, tv, coef, coefa;
  logic [4:0]         idx;

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;

  // combinational helpers
  logic [33:0]        rem_sh;
  logic               dv_ge;
  logic [63:0]        sq_sum;
  logic               sq_ge;
  logic signed [67:0] pr30, pr28, pr30_mag;
  logic [63:0]        r64;
  logic [37:0]        ang_mag;
  logic [31:0]        ix_mag, iy_mag, iz_mag, max3, max2;
  logic [3:0]         l_sat;
  logic [4:0]         am_in;
  logic [11:0]        esq, e1sq, msq, num_a, den_a, num_b, den_b;
  logic [4:0]         em1;

  assign rem_sh   = {rem, dv_n[71]};
  assign dv_ge    = rem_sh >= {1'b0, dv_d};
  assign sq_sum   = sq_res + sq_bit;
  assign sq_ge    = sq_v >= sq_sum;
  assign pr30     = rnd30(prod);
  assign pr28     = rnd28(prod);
  assign pr30_mag = (pr30 < 0) ? -pr30 : pr30;
  assign r64      = {ang[31:0], 32'b0} - {prod[31:0], 32'b0} - acc[63:0];
  assign ang_mag  = (ang < 0) ? 38'(-ang) : 38'(ang);

  assign ix_mag = x_coord[31] ? 32'(-x_coord) : 32'(x_coord);
  assign iy_mag = y_coord[31] ? 32'(-y_coord) : 32'(y_coord);
  assign iz_mag = z_coord[31] ? 32'(-z_coord) : 32'(z_coord);
  assign l_sat  = (degree > 4'(LSAT)) ? 4'(LSAT) : degree;
  assign am_in  = order[4] ? 5'(-order) : 5'(order);
  assign max2   = (ax > ay) ? ax : ay;
  assign max3   = (az > max2) ? az : max2;

  assign em1   = idx - 5'd1;
  assign esq   = 12'(idx) * 12'(idx);
  assign e1sq  = 12'(em1) * 12'(em1);
  assign msq   = 12'(am) * 12'(am);
  assign num_a = 12'(esq << 2) - 12'd1;
  assign den_a = esq - msq;
  assign num_b = e1sq - msq;
  assign den_b = 12'(e1sq << 2) - 12'd1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      C_MX, C_PMX: begin mul_a = $signed({2'b00, xs}); mul_b = $signed({2'b00, xs}); end
      C_MY, C_PMY: begin mul_a = $signed({2'b00, ys}); mul_b = $signed({2'b00, ys}); end
      C_MZ:        begin mul_a = $signed({2'b00, zs}); mul_b = $signed({2'b00, zs}); end
      C_ROT:       begin mul_a = cm; mul_b = c1; end
      C_R2:        begin mul_a = sm; mul_b = s1; end
      C_R3:        begin mul_a = sm; mul_b = c1; end
      C_R4:        begin mul_a = cm; mul_b = s1; end
      A_PH: begin
        mul_a = $signed({29'b0, am});
        mul_b = $signed({{2{ph_r[31]}}, ph_r});
      end
      SC_K3: begin mul_a = $signed({{25{k[8]}}, k}); mul_b = $signed({2'b00, Q60_LO}); end
      SC_K4: begin mul_a = $signed({{25{k[8]}}, k}); mul_b = $signed({2'b00, Q60_HI}); end
      SC_X:        begin mul_a = rv; mul_b = rv; end
      SC_T:        begin mul_a = ts; mul_b = x2; end
      SC_T3:       begin mul_a = tc; mul_b = x2; end
      L_K2:        begin mul_a = p; mul_b = s; end
      L_K4, L_M4:  begin mul_a = tv; mul_b = coef; end
      L_CHK:       begin mul_a = p; mul_b = c; end
      L_E4:        begin mul_a = c; mul_b = p1; end
      L_E5:        begin mul_a = coef; mul_b = p0; end
      L_E7:        begin mul_a = coefa; mul_b = tv; end
      FIN:         begin mul_a = p1; mul_b = SQRT2_Q30; end
      FIN3: begin
        mul_a = tv;
        mul_b = (ord_r > 5'sd0) ? cm : sm;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            func_r <= func;
            l_r    <= l_sat;
            ord_r  <= order;
            am     <= am_in;
            ax     <= ix_mag;
            ay     <= iy_mag;
            az     <= iz_mag;
            xneg   <= x_coord[31];
            yneg   <= y_coord[31];
            zneg   <= z_coord[31];
            th_r   <= polar_angle;
            ph_r   <= azimuth_angle;
            if (!func && x_coord == 32'sd0 && y_coord == 32'sd0 && z_coord == 32'sd0)
              status_r <= ST_ORIGIN;
            else if (am_in > {1'b0, l_sat})
              status_r <= ST_ORDER;
            else
              status_r <= ST_OK;
            state <= START;
          end
        end
        START: begin
          if (status_r != ST_OK) begin
            value_r <= '0;
            state   <= DONE;
          end else if (!func_r) begin
            nrm   <= max3;
            sh    <= '0;
            ret   <= C_SH;
            state <= NORM;
          end else begin
            ang    <= 38'(th_r);
            ret_sc <= A_PH;
            state  <= SC_K;
          end
        end

        // shared units
        DIVS: begin
          rem  <= dv_ge ? 33'(rem_sh - {1'b0, dv_d}) : rem_sh[32:0];
          quo  <= {quo[62:0], dv_ge};
          dv_n <= dv_n << 1;
          cnt  <= cnt - 7'd1;
          if (cnt == 7'd1) state <= ret;
        end
        SQRT: begin
          if (sq_ge) begin
            sq_v   <= sq_v - sq_sum;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt - 7'd1;
          if (cnt == 7'd1) state <= ret;
        end
        NORM: begin
          if (nrm[31:30] == 2'b00) begin
            nrm <= nrm << 1;
            sh  <= sh + 5'd1;
          end else begin
            state <= ret;
          end
        end

        // Cartesian point
        C_SH: begin
          xs    <= ax << sh;
          ys    <= ay << sh;
          zs    <= az << sh;
          state <= C_MX;
        end
        C_MX: state <= C_MY;
        C_MY: begin
          acc   <= prod;
          state <= C_MZ;
        end
        C_MZ: begin
          acc   <= acc + prod;
          state <= C_R;
        end
        C_R: begin
          sq_v   <= 64'(acc + prod);
          sq_res <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          cnt    <= 7'd32;
          ret    <= C_RHO;
          state  <= SQRT;
        end
        C_RHO: begin
          rr     <= sq_res[32:0];
          sq_v   <= acc[63:0];
          sq_res <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          cnt    <= 7'd32;
          ret    <= C_DC;
          state  <= SQRT;
        end
        C_DC: begin
          acc   <= 68'(sq_res);
          dv_n  <= {(64'(zs) << 30) + 64'(rr >> 1), 8'b0};
          dv_d  <= rr;
          rem   <= '0;
          quo   <= '0;
          cnt   <= 7'd64;
          ret   <= C_DS;
          state <= DIVS;
        end
        C_DS: begin
          c     <= div_fin(quo, zneg);
          dv_n  <= {(64'(acc) << 30) + 64'(rr >> 1), 8'b0};
          rem   <= '0;
          quo   <= '0;
          cnt   <= 7'd64;
          ret   <= C_PH;
          state <= DIVS;
        end
        C_PH: begin
          s   <= div_fin(quo, 1'b0);
          cm  <= ONE30;
          sm  <= '0;
          idx <= '0;
          if (max2 == 32'd0) begin
            // on the z axis: phi is zero
            c1    <= ONE30;
            s1    <= '0;
            state <= C_ROT;
          end else begin
            nrm   <= max2;
            sh    <= '0;
            ret   <= C_PSH;
            state <= NORM;
          end
        end
        C_PSH: begin
          xs    <= ax << sh;
          ys    <= ay << sh;
          state <= C_PMX;
        end
        C_PMX: state <= C_PMY;
        C_PMY: begin
          acc   <= prod;
          state <= C_PR;
        end
        C_PR: begin
          sq_v   <= 64'(acc + prod);
          sq_res <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          cnt    <= 7'd32;
          ret    <= C_PDC;
          state  <= SQRT;
        end
        C_PDC: begin
          rr    <= sq_res[32:0];
          dv_n  <= {(64'(xs) << 30) + (sq_res >> 1), 8'b0};
          dv_d  <= sq_res[32:0];
          rem   <= '0;
          quo   <= '0;
          cnt   <= 7'd64;
          ret   <= C_PDS;
          state <= DIVS;
        end
        C_PDS: begin
          c1    <= div_fin(quo, xneg);
          dv_n  <= {(64'(ys) << 30) + 64'(rr >> 1), 8'b0};
          rem   <= '0;
          quo   <= '0;
          cnt   <= 7'd64;
          ret   <= C_PEND;
          state <= DIVS;
        end
        C_PEND: begin
          s1    <= div_fin(quo, yneg);
          state <= C_ROT;
        end
        // cos/sin of m*phi by repeated complex products
        C_ROT: state <= (idx == am) ? L_START : C_R2;
        C_R2: begin
          acc   <= prod;
          state <= C_R3;
        end
        C_R3: begin
          acc   <= acc - prod;
          state <= C_R4;
        end
        C_R4: begin
          acc2  <= prod;
          state <= C_R5;
        end
        C_R5: begin
          cm    <= clamp30(rnd30(acc));
          sm    <= clamp30(rnd30(acc2 + prod));
          idx   <= idx + 5'd1;
          state <= C_ROT;
        end

        // angles
        A_PH: begin
          c     <= sc_c;
          s     <= (sc_s < 0) ? -sc_s : sc_s;
          state <= A_PH2;
        end
        A_PH2: begin
          ang    <= 38'(prod);
          ret_sc <= A_END;
          state  <= SC_K;
        end
        A_END: begin
          cm    <= sc_c;
          sm    <= sc_s;
          state <= L_START;
        end

        // sine/cosine: quadrant reduction, then Taylor series
        SC_K: begin
          dv_n  <= {40'(ang_mag) + HALF_PI_Q28_HALF, 32'b0};
          dv_d  <= HALF_PI_Q28;
          rem   <= '0;
          quo   <= '0;
          cnt   <= 7'd40;
          ret   <= SC_K2;
          state <= DIVS;
        end
        SC_K2: begin
          k     <= (ang < 0) ? -$signed(quo[8:0]) : $signed(quo[8:0]);
          state <= SC_K3;
        end
        SC_K3: state <= SC_K4;
        SC_K4: begin
          acc   <= prod;
          state <= SC_K5;
        end
        SC_K5: begin
          rv    <= 34'(rnd30($signed({{4{r64[63]}}, r64})));
          state <= SC_X;
        end
        SC_X: state <= SC_X2;
        SC_X2: begin
          x2    <= 34'(pr30);
          ts    <= rv;
          st    <= rv;
          tc    <= ONE30;
          ct    <= ONE30;
          ti    <= 3'd1;
          state <= SC_T;
        end
        SC_T: state <= SC_T2;
        SC_T2: begin
          tneg  <= pr30 < 0;
          dv_n  <= {pr30_mag[39:0], 32'b0};
          dv_d  <= 33'(sin_div(ti));
          rem   <= '0;
          quo   <= '0;
          cnt   <= 7'd40;
          ret   <= SC_T3;
          state <= DIVS;
        end
        SC_T3: begin
          ts    <= tneg ? $signed(quo[33:0]) : -$signed(quo[33:0]);
          st    <= st + (tneg ? $signed(quo[33:0]) : -$signed(quo[33:0]));
          state <= SC_T4;
        end
        SC_T4: begin
          tneg  <= pr30 < 0;
          dv_n  <= {pr30_mag[39:0], 32'b0};
          dv_d  <= 33'(cos_div(ti));
          rem   <= '0;
          quo   <= '0;
          cnt   <= 7'd40;
          ret   <= SC_T5;
          state <= DIVS;
        end
        SC_T5: begin
          tc <= tneg ? $signed(quo[33:0]) : -$signed(quo[33:0]);
          ct <= ct + (tneg ? $signed(quo[33:0]) : -$signed(quo[33:0]));
          if (ti == 3'd7) begin
            state <= SC_Q;
          end else begin
            ti    <= ti + 3'd1;
            state <= SC_T;
          end
        end
        SC_Q: begin
          case (k[1:0])
            2'd0: begin sc_c <= clamp30(68'(ct));  sc_s <= clamp30(68'(st));  end
            2'd1: begin sc_c <= clamp30(-68'(st)); sc_s <= clamp30(68'(ct));  end
            2'd2: begin sc_c <= clamp30(-68'(ct)); sc_s <= clamp30(-68'(st)); end
            default: begin sc_c <= clamp30(68'(st)); sc_s <= clamp30(-68'(ct)); end
          endcase
          state <= ret_sc;
        end

        // normalized Legendre, diagonal first
        L_START: begin
          p     <= INV_SQRT_4PI_Q28;
          idx   <= 5'd1;
          state <= L_K;
        end
        L_K: begin
          if (idx > am) begin
            state <= L_CHK;
          end else begin
            dv_n  <= 72'({idx, 1'b1}) << 56;
            dv_d  <= 33'({idx, 1'b0});
            rem   <= '0;
            quo   <= '0;
            cnt   <= 7'd72;
            ret   <= L_K1;
            state <= DIVS;
          end
        end
        L_K1: begin
          sq_v   <= quo;
          sq_res <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          cnt    <= 7'd32;
          ret    <= L_K2;
          state  <= SQRT;
        end
        L_K2: begin
          coef  <= $signed({1'b0, sq_res[32:0]});
          state <= L_K3;
        end
        L_K3: begin
          tv    <= 34'(pr30);
          state <= L_K4;
        end
        L_K4: state <= L_K5;
        L_K5: begin
          p     <= clamp31(-pr28);
          idx   <= idx + 5'd1;
          state <= L_K;
        end
        L_CHK: begin
          p0 <= p;
          p1 <= p;
          state <= ({1'b0, l_r} == am) ? FIN : L_M1;
        end
        L_M1: begin
          tv    <= 34'(pr30);
          dv_n  <= 72'({am, 1'b1} + 6'd2) << 56;
          dv_d  <= 33'd1;
          rem   <= '0;
          quo   <= '0;
          cnt   <= 7'd72;
          ret   <= L_M2;
          state <= DIVS;
        end
        L_M2: begin
          sq_v   <= quo;
          sq_res <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          cnt    <= 7'd32;
          ret    <= L_M3;
          state  <= SQRT;
        end
        L_M3: begin
          coef  <= $signed({1'b0, sq_res[32:0]});
          state <= L_M4;
        end
        L_M4: state <= L_M5;
        L_M5: begin
          p1    <= clamp31(pr28);
          idx   <= am + 5'd2;
          state <= L_E;
        end
        L_E: begin
          if (idx > {1'b0, l_r}) begin
            state <= FIN;
          end else begin
            dv_n  <= 72'(num_a) << 56;
            dv_d  <= 33'(den_a);
            rem   <= '0;
            quo   <= '0;
            cnt   <= 7'd72;
            ret   <= L_E1;
            state <= DIVS;
          end
        end
        L_E1: begin
          sq_v   <= quo;
          sq_res <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          cnt    <= 7'd32;
          ret    <= L_E2;
          state  <= SQRT;
        end
        L_E2: begin
          coefa <= $signed({1'b0, sq_res[32:0]});
          dv_n  <= 72'(num_b) << 56;
          dv_d  <= 33'(den_b);
          rem   <= '0;
          quo   <= '0;
          cnt   <= 7'd72;
          ret   <= L_E3;
          state <= DIVS;
        end
        L_E3: begin
          sq_v   <= quo;
          sq_res <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          cnt    <= 7'd32;
          ret    <= L_E4;
          state  <= SQRT;
        end
        L_E4: begin
          coef  <= $signed({1'b0, sq_res[32:0]});
          state <= L_E5;
        end
        L_E5: begin
          acc   <= pr30;
          state <= L_E6;
        end
        L_E6: begin
          tv    <= clamp31(acc - pr28);
          state <= L_E7;
        end
        L_E7: state <= L_E8;
        L_E8: begin
          p0    <= p1;
          p1    <= clamp31(pr28);
          idx   <= idx + 5'd1;
          state <= L_E;
        end

        // azimuthal factor and output saturation
        FIN: begin
          if (ord_r == 5'sd0) begin
            value_r <= sat32(68'(p1));
            state   <= DONE;
          end else begin
            state <= FIN2;
          end
        end
        FIN2: begin
          tv    <= 34'(pr30);
          state <= FIN3;
        end
        FIN3: state <= FIN4;
        FIN4: begin
          value_r <= sat32(pr30);
          state   <= DONE;
        end
        DONE: begin
          if (!out_stall) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign in_stall  = (state != IDLE);
  assign out_valid = (state == DONE);
  assign value     = value_r;
  assign status    = status_r;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> value == 32'sd0)
    else $error("nonzero value with error status");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_ORDER || status == ST_ORIGIN)
    else $error("illegal status code");
  a_unit_count: assert property (@(posedge clk) disable iff (rst)
    state == DIVS || state == SQRT |-> cnt != 7'd0)
    else $error("shared unit running with zero count");
  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == NORM |-> nrm != 32'd0)
    else $error("normalize on zero magnitude");
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result in the cycle after a request");
`endif

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for real_spherical_harmonic_eval. Requests carry either
// a Cartesian point or a polar/azimuth angle pair. An in-bench fixed-point
// model predicts value and status for each accepted request. Both handshakes
// are throttled in several idle/stall phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rshe_pkg::*;

  localparam longint ONE = 64'sd1 <<< 30;
  localparam longint HPI28 = 421657428;
  localparam bit [63:0] HPI60 = 64'h1921FB54442D1847;
  localparam longint NORM0 = 75724244;
  localparam longint RT2 = 1518500250;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic func = 0;
  logic [3:0] degree = '0;
  logic signed [4:0] order = '0;
  logic signed [31:0] x_coord = '0, y_coord = '0, z_coord = '0;
  logic signed [31:0] polar_angle = '0, azimuth_angle = '0;
  logic in_stall, out_valid;
  logic signed [31:0] value;
  logic [1:0] status;

  typedef struct packed {
    logic signed [31:0] val;
    logic [1:0] st;
  } harmonic_t;

  harmonic_t harmonics_due[$];
  int errors = 0;
  int send_gap_pct = 0, stall_pct = 0;

  real_spherical_harmonic_eval dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // ---------------- fixed-point harmonic model ----------------
  function automatic longint rnd_sh(longint v, int s);
    logic signed [64:0] w;
    w = v;
    w = w + (65'sd1 <<< (s - 1));
    return longint'(w >>> s);
  endfunction

  function automatic longint clampl(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else res >>= 1;
      bt >>= 2;
    end
    return res;
  endfunction

  // sqrt(num/den) in Q28
  function automatic longint root_ratio(int unsigned num, int unsigned den);
    bit [63:0] q, r;
    q = num / den;
    r = num % den;
    for (int i = 0; i < 56; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return longint'(int_sqrt(q));
  endfunction

  function automatic int unsigned lead_shift(bit [63:0] mx);
    int unsigned s;
    s = 0;
    while ((mx << s) < (64'd1 << 30)) s++;
    return s;
  endfunction

  function automatic longint unit_div(bit [63:0] n, bit [63:0] d, bit neg);
    longint q;
    q = longint'((n + d / 2) / d);
    if (q > ONE) q = ONE;
    return neg ? -q : q;
  endfunction

  task automatic angle_trig(longint a, output longint cs, output longint sn);
    longint k, r, x2, st, ct, ts, tc, c, s;
    bit [63:0] u;
    if (a >= 0) k = (a + HPI28 / 2) / HPI28;
    else k = -((-a + HPI28 / 2) / HPI28);
    u = (64'(a) << 32) - 64'(k) * HPI60;
    r = rnd_sh(longint'(u), 30);
    x2 = rnd_sh(r * r, 30);
    ts = r; st = r; tc = ONE; ct = ONE;
    for (int i = 1; i <= 7; i++) begin
      ts = -(rnd_sh(ts * x2, 30) / longint'((2 * i) * (2 * i + 1)));
      tc = -(rnd_sh(tc * x2, 30) / longint'((2 * i - 1) * (2 * i)));
      st += ts;
      ct += tc;
    end
    case (k & 3)
      0: begin c = ct; s = st; end
      1: begin c = -st; s = ct; end
      2: begin c = -ct; s = -st; end
      default: begin c = st; s = -ct; end
    endcase
    cs = clampl(c, ONE);
    sn = clampl(s, ONE);
  endtask

  function automatic longint legendre_norm(int unsigned l, int unsigned m, longint c,
                                           longint s);
    longint lim, p, p0, p1, t, a, b;
    lim = 64'sd1 <<< 31;
    p = NORM0;
    for (int unsigned k = 1; k <= m; k++) begin
      t = rnd_sh(p * s, 30);
      p = clampl(-rnd_sh(t * root_ratio(2 * k + 1, 2 * k), 28), lim);
    end
    if (l == m) return p;
    p0 = p;
    p1 = clampl(rnd_sh(rnd_sh(p * c, 30) * root_ratio(2 * m + 3, 1), 28), lim);
    for (int unsigned e = m + 2; e <= l; e++) begin
      a = root_ratio(4 * e * e - 1, e * e - m * m);
      b = root_ratio((e - 1) * (e - 1) - m * m, 4 * (e - 1) * (e - 1) - 1);
      t = clampl(rnd_sh(c * p1, 30) - rnd_sh(b * p0, 28), lim);
      p0 = p1;
      p1 = clampl(rnd_sh(a * t, 28), lim);
    end
    return p1;
  endfunction

  task automatic predict_harmonic(logic f, logic [3:0] l_in, logic signed [4:0] m_in,
                                  logic signed [31:0] xi, yi, zi, th, ph,
                                  output harmonic_t res);
    longint x, y, z, v, c, s, cm, sm, c1, s1, nc, ns, t;
    bit [63:0] ax, ay, az, mx, bx, by, bz, r, rho, x2, y2, rp;
    int unsigned l, am, sh;
    l = l_in;
    am = (m_in < 0) ? -int'(m_in) : int'(m_in);
    x = xi; y = yi; z = zi;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    res.val = 0;
    res.st = ST_OK;
    if (f == 1'b0 && ax == 0 && ay == 0 && az == 0) res.st = ST_ORIGIN;
    else if (am > l) res.st = ST_ORDER;
    if (res.st != ST_OK) return;
    cm = ONE; sm = 0;
    if (f == 1'b0) begin
      c1 = ONE; s1 = 0;
      mx = (ax > ay) ? ax : ay;
      if (az > mx) mx = az;
      sh = lead_shift(mx);
      bx = ax << sh; by = ay << sh; bz = az << sh;
      r = int_sqrt(bx * bx + by * by + bz * bz);
      rho = int_sqrt(bx * bx + by * by);
      c = unit_div(bz << 30, r, z < 0);
      s = unit_div(rho << 30, r, 0);
      mx = (ax > ay) ? ax : ay;
      if (mx != 0) begin
        sh = lead_shift(mx);
        x2 = ax << sh; y2 = ay << sh;
        rp = int_sqrt(x2 * x2 + y2 * y2);
        c1 = unit_div(x2 << 30, rp, x < 0);
        s1 = unit_div(y2 << 30, rp, y < 0);
      end
      for (int unsigned i = 0; i < am; i++) begin
        nc = clampl(rnd_sh(cm * c1 - sm * s1, 30), ONE);
        ns = clampl(rnd_sh(sm * c1 + cm * s1, 30), ONE);
        cm = nc; sm = ns;
      end
    end else begin
      angle_trig(longint'(th), c, s);
      if (s < 0) s = -s;
      angle_trig(longint'(am) * longint'(ph), cm, sm);
    end
    v = legendre_norm(l, am, c, s);
    if (m_in != 0) begin
      t = rnd_sh(v * RT2, 30);
      v = rnd_sh(t * ((m_in > 0) ? cm : sm), 30);
    end
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    res.val = v[31:0];
  endtask

  // ---------------- driving and checking ----------------
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic send_request(logic f, logic [3:0] l, logic signed [4:0] m,
                              logic signed [31:0] xi, yi, zi, th, ph);
    harmonic_t exp_res;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1;
    func <= f; degree <= l; order <= m;
    x_coord <= xi; y_coord <= yi; z_coord <= zi;
    polar_angle <= th; azimuth_angle <= ph;
    predict_harmonic(f, l, m, xi, yi, zi, th, ph, exp_res);
    do @(posedge clk); while (in_stall);
    harmonics_due.push_back(exp_res);
  endtask

  always @(posedge clk) begin
    harmonic_t e;
    if (!rst && out_valid && !out_stall) begin
      if (harmonics_due.size() == 0) begin
        $display("%t unexpected result value=%0d status=%0d", $realtime, value, status);
        errors++;
      end else begin
        e = harmonics_due.pop_front();
        if (value !== e.val || status !== e.st) begin
          $display("%t mismatch: expected value=%0d status=%0d, actual value=%0d status=%0d",
                   $realtime, e.val, e.st, value, status);
          errors++;
        end
      end
    end
  end

  // coordinates and angles over a spread of magnitudes
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom) >>> $urandom_range(31);
      2: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      3: return $signed($urandom_range(8)) - 4;
      default: return $signed($urandom) >>> $urandom_range(8);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_angle();
    if ($urandom_range(9) == 0) return $urandom;
    return $signed($urandom) >>> $urandom_range(1, 6);
  endfunction

  function automatic logic [3:0] rand_degree();
    return ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
  endfunction

  function automatic logic signed [4:0] rand_order(logic [3:0] l);
    int m;
    if ($urandom_range(9) == 0) return 5'($urandom);
    m = $urandom_range(l);
    return $urandom_range(1) ? 5'(-m) : 5'(m);
  endfunction

  // ---------------- tests ----------------
  task automatic test_special_cases();
    send_request(0, 3, 1, 0, 0, 0, 1, 1);                  // origin
    send_request(0, 2, 5'sd9, 0, 0, 0, 0, 0);             // origin wins over order
    send_request(0, 15, -5'sd16, 1, 2, 3, 0, 0);          // order -16
    send_request(1, 4, 5, 0, 0, 0, 100, 100);             // |m| > l on angles
    send_request(0, 0, 0, 5, -7, 9, 0, 0);
    send_request(1, 0, 0, 0, 0, 0, 0, 0);                 // origin ignored for angles
    send_request(0, 15, 15, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0, 0);
    send_request(0, 15, -15, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0);
    send_request(0, 6, 3, 0, 0, 1000, 0, 0);              // on z axis
    send_request(0, 6, -3, 0, 0, -1, 0, 0);
    send_request(0, 5, 2, 1, 0, 0, 0, 0);
    send_request(0, 5, -2, 0, -1, 0, 0, 0);
    send_request(1, 15, 15, 0, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_request(1, 15, -15, 0, 0, 0, 32'sh80000000, 32'sh80000000);
    send_request(1, 8, 0, 0, 0, 0, 421657428, 0);         // theta = pi/2
    send_request(1, 9, 4, 0, 0, 0, 843314856, -843314856);
    send_request(1, 7, -7, 32'sh7FFFFFFF, -1, 5, -421657428, 210828714);
    send_request(1, 1, 1, 0, 0, 0, 0, 0);                 // theta = 0
    send_request(0, 10, 10, -3, 4, 0, 0, 0);
    send_request(0, 12, -6, 1, 1, 1, 0, 0);
  endtask

  task automatic test_points(int n);
    logic [3:0] l;
    for (int i = 0; i < n; i++) begin
      l = rand_degree();
      if ($urandom_range(29) == 0)
        send_request(0, l, rand_order(l), 0, 0, 0, $urandom, $urandom);
      else
        send_request(0, l, rand_order(l), rand_word(), rand_word(), rand_word(),
                     $urandom, $urandom);
    end
  endtask

  task automatic test_angles(int n);
    logic [3:0] l;
    for (int i = 0; i < n; i++) begin
      l = rand_degree();
      send_request(1, l, rand_order(l), $urandom, $urandom, $urandom,
                   rand_angle(), rand_angle());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    test_special_cases();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0; stall_pct = 0; end
        1: begin send_gap_pct = 47; stall_pct = 0; end
        2: begin send_gap_pct = 0; stall_pct = 47; end
        default: begin send_gap_pct = 7; stall_pct = 7; end
      endcase
      test_points(85);
      test_angles(85);
    end
    in_valid <= 0;
    while (harmonics_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("[real_spherical_harmonic_eval] OK");
    else $display("[real_spherical_harmonic_eval] ERROR");
    $finish;
  end

  initial begin
    #400ms;
    $display("[real_spherical_harmonic_eval] ERROR");
    $finish;
  end
endmodule

// File: sim.f
rtl/rshe_pkg.sv
rtl/real_spherical_harmonic_eval.sv
dv/tb.sv
